// File: rtl/lpd_pkg.sv
// Shared types and constants for the length-prefixed deframer.
// Holds the counter width, register indexes and the command passed front to back.
// No dependencies.
package lpd_pkg;

    localparam int COUNT_BITS = 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam int LEN_BITS = 16;
    localparam int HDR_BITS = 8;
    localparam logic [HDR_BITS-1:0] HDR_MIN = 8'd4;
    // the last position at which the header can still be open
    localparam logic [COUNT_BITS-1:0] HDR_LAST_POS = COUNT_BITS'(254);

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 8;

    localparam int QUEUE_DEPTH = 2;   // power of two, pointers wrap naturally
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_HEADER_BYTES = 2'd0,
        REG_LENGTH_BE    = 2'd1
    } t_reg_idx;

    localparam logic ACT_DATA   = 1'b0;
    localparam logic ACT_FLUSH  = 1'b1;
    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef struct packed {
        logic                flush;
        logic [7:0]          data;
        logic [HDR_BITS-1:0] hdr;         // effective header size, at least four
        logic                big_endian;
    } t_cmd;

endpackage

// File: rtl/lpd_front.sv
// Front end of the deframer: configuration registers and beat classification.
// Turns each accepted input beat into a command for the queue.
// Depends on lpd_pkg.
module lpd_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [lpd_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [lpd_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                         i_valid,
    input  logic                         i_action,
    input  logic [7:0]                   i_data_byte,
    input  logic                         i_q_full,
    output logic                         o_stall,
    output logic                         o_push,
    output lpd_pkg::t_cmd                o_cmd
);
    import lpd_pkg::*;

    logic [HDR_BITS-1:0] r_header_bytes;
    logic                r_length_be;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_bytes <= HDR_MIN;
            r_length_be    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_HEADER_BYTES: r_header_bytes <= i_cfg_data[HDR_BITS-1:0];
                REG_LENGTH_BE:    r_length_be    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_stall        = i_q_full;
        o_push         = i_valid && !i_q_full;
        o_cmd.flush    = (i_action == ACT_FLUSH);
        o_cmd.data     = o_cmd.flush ? 8'd0 : i_data_byte;
        // clamp a short header setting up to the length word size
        o_cmd.hdr      = (r_header_bytes < HDR_MIN) ? HDR_MIN : r_header_bytes;
        o_cmd.big_endian = r_length_be;
    end

endmodule

// File: rtl/lpd_queue.sv
// Short command queue between the deframer front and back ends.
// Two entries, so either side may stall without holding the other.
// Depends on lpd_pkg.
module lpd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lpd_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_pop,
    output lpd_pkg::t_cmd o_cmd
);
    import lpd_pkg::*;

    t_cmd                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;
    logic [QCNT_BITS-1:0] n_count;
    logic                 push;
    logic                 pop;

    always_comb begin
        o_full  = (r_count == QCNT_BITS'(QUEUE_DEPTH));
        o_valid = (r_count != '0);
        push    = i_push && !o_full;
        pop     = i_pop && o_valid;
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
        o_cmd = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

// File: rtl/lpd_back.sv
// Back end of the deframer: packet state, length capture and the output register.
// Pops one command per free output slot and marks offsets and packet ends.
// Depends on lpd_pkg.
module lpd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  lpd_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic          o_kind,
    output logic [7:0]    o_out_byte,
    output logic [15:0]   o_byte_offset,
    output logic          o_packet_end,
    output logic [15:0]   o_partial_count
);
    import lpd_pkg::*;

    logic [COUNT_BITS-1:0] r_seen;
    logic [LEN_BITS-1:0]   r_len_word;
    logic [COUNT_BITS-1:0] r_plen;
    logic                  r_valid;
    logic                  r_kind;
    logic [7:0]            r_byte;
    logic [15:0]           r_offset;
    logic                  r_end;
    logic [15:0]           r_partial;

    logic [COUNT_BITS-1:0] n_seen;
    logic [LEN_BITS-1:0]   n_len_word;
    logic [COUNT_BITS-1:0] n_plen;
    logic [COUNT_BITS:0]   pos1;
    logic [LEN_BITS-1:0]   word;
    logic [LEN_BITS:0]     len;
    logic                  pkt_end;

    always_comb begin
        o_pop = i_q_valid && (!r_valid || !i_stall);
        pos1  = {1'b0, r_seen} + 1'b1;

        // only the low half of the length word is ever used
        word = r_len_word;
        if (r_seen < COUNT_BITS'(4)) begin
            if (i_cmd.big_endian) begin
                word = {r_len_word[7:0], i_cmd.data};
            end else if (r_seen == '0) begin
                word = r_len_word | {8'd0, i_cmd.data};
            end else if (r_seen == COUNT_BITS'(1)) begin
                word = r_len_word | {i_cmd.data, 8'd0};
            end
        end

        n_plen = r_plen;
        len    = {1'b0, word};
        if (r_plen == '0 && pos1 >= (COUNT_BITS+1)'(i_cmd.hdr)) begin
            if (len < (LEN_BITS+1)'(i_cmd.hdr)) begin
                len = (LEN_BITS+1)'(i_cmd.hdr);
            end
            if (len > (LEN_BITS+1)'(COUNT_MAX)) begin
                len = (LEN_BITS+1)'(COUNT_MAX);
            end
            if (len < (LEN_BITS+1)'(pos1)) begin
                len = (LEN_BITS+1)'(pos1);
            end
            n_plen = len[COUNT_BITS-1:0];
        end

        pkt_end    = (n_plen != '0) && (pos1 >= {1'b0, n_plen});
        n_seen     = pos1[COUNT_BITS-1:0];
        n_len_word = word;
        if (i_cmd.flush || pkt_end) begin
            n_seen     = '0;
            n_len_word = '0;
            n_plen     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= '0;
            r_len_word <= '0;
            r_plen     <= '0;
            r_valid    <= 1'b0;
        end else begin
            if (o_pop) begin
                r_seen     <= n_seen;
                r_len_word <= n_len_word;
                r_plen     <= n_plen;
                r_valid    <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // hold the result while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind    <= i_cmd.flush ? KIND_FLUSH : KIND_DATA;
            r_byte    <= i_cmd.data;
            r_offset  <= i_cmd.flush ? 16'd0 : 16'(r_seen);
            r_end     <= !i_cmd.flush && pkt_end;
            r_partial <= i_cmd.flush ? 16'(r_seen) : 16'd0;
        end
    end

    assign o_valid         = r_valid;
    assign o_kind          = r_kind;
    assign o_out_byte      = r_byte;
    assign o_byte_offset   = r_offset;
    assign o_packet_end    = r_end;
    assign o_partial_count = r_partial;

`ifndef NO_ASSERTIONS
    a_seen_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_plen != '0) |-> (r_seen < r_plen))
        else $error("byte count reached packet length without an end");

    a_header_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_plen == '0) |-> (r_seen <= HDR_LAST_POS))
        else $error("header still open past its largest size");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_cmd.flush) |=> (r_seen == '0 && r_plen == '0 && r_len_word == '0))
        else $error("flush left packet state behind");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && !i_cmd.flush && pkt_end) |=> (r_seen == '0 && r_plen == '0))
        else $error("packet end left packet state behind");
`endif

endmodule

// File: rtl/length_prefixed_deframer.sv
// Length-prefixed packet deframer, top level.
// Input channel: i_valid / o_stall with i_action and i_data_byte; a beat is taken
// at a clock edge with i_valid high and o_stall low. A data beat carries one stream
// byte, a flush beat ends the current partial packet.
// Output channel: o_valid / i_stall; one result beat per input beat, in order.
// Data beats return the byte, its offset in the packet and o_packet_end on the
// last byte; a flush returns o_kind = 1 with the held byte count, zero included.
// The packet length is the low 16 bits of the 32-bit word in header bytes 0..3,
// little or big endian per register; it counts the header and is never taken
// below the header size.
// Configuration: i_cfg_we writes register i_cfg_idx (0 header bytes, 1 big
// endian) from i_cfg_data; unknown indexes are ignored. Write only while idle.
// Each taken beat passes through the queue and the back-end output register before
// o_valid shows its result. Throughput: one beat per cycle while i_stall is low,
// as the back end updates packet state on every pop.
// A two-entry queue sits between front and back; when the receiver stalls the
// output register holds and the queue fills, then o_stall rises.
// Reset (i_rst_n low, synchronous) empties the queue, clears packet state and
// restores header bytes 4, little endian.
// Depends on lpd_pkg, lpd_front, lpd_queue, lpd_back.
module length_prefixed_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [lpd_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [lpd_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_kind,
    output logic [7:0]  o_out_byte,
    output logic [15:0] o_byte_offset,
    output logic        o_packet_end,
    output logic [15:0] o_partial_count
);
    import lpd_pkg::*;

    t_cmd front_cmd;
    t_cmd head_cmd;
    logic push;
    logic q_full;
    logic q_valid;
    logic pop;

    lpd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .i_action    (i_action),
        .i_data_byte (i_data_byte),
        .i_q_full    (q_full),
        .o_stall     (o_stall),
        .o_push      (push),
        .o_cmd       (front_cmd)
    );

    lpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_cmd   (head_cmd)
    );

    lpd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_cmd           (head_cmd),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kind          (o_kind),
        .o_out_byte      (o_out_byte),
        .o_byte_offset   (o_byte_offset),
        .o_packet_end    (o_packet_end),
        .o_partial_count (o_partial_count)
    );

endmodule

// File: tb/length_prefixed_deframer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the length-prefixed deframer: queue-fed beat driver,
// clocked result monitor and a beat-level packet predictor kept in this file.
// Depends on lpd_pkg and length_prefixed_deframer.
module length_prefixed_deframer_tb;
    import lpd_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_BEATS   = 1700;
    // indexes that decode to no register
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = 2'd3;

    typedef struct {
        logic       action;
        logic [7:0] data;
    } t_in_beat;

    typedef struct {
        logic        kind;
        logic [7:0]  out_byte;
        logic [15:0] byte_offset;
        logic        packet_end;
        logic [15:0] partial_count;
    } t_out_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_action = ACT_DATA;
    logic [7:0]  i_data_byte = 8'h00;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_kind;
    logic [7:0]  o_out_byte;
    logic [15:0] o_byte_offset;
    logic        o_packet_end;
    logic [15:0] o_partial_count;

    length_prefixed_deframer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_data_byte    (i_data_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_out_byte     (o_out_byte),
        .o_byte_offset  (o_byte_offset),
        .o_packet_end   (o_packet_end),
        .o_partial_count(o_partial_count)
    );

    always #2 i_clk = ~i_clk;

    // register shadows and packet state of the predictor
    logic [HDR_BITS-1:0] hdr_setting = HDR_MIN;
    logic                be_setting = 1'b0;
    logic [15:0]         frame_pos = '0;
    logic [31:0]         len_word = '0;
    logic [15:0]         frame_len = '0;

    t_in_beat  pending_beats[$];
    t_out_beat expected_beats[$];

    bit          in_idle_on = 1'b0;
    bit          out_idle_on = 1'b0;
    bit          in_busy = 1'b0;
    bit          in_taken = 1'b0;
    int unsigned in_gap = 0;
    int unsigned stall_left = 0;
    int unsigned beats_queued = 0;
    int unsigned fail_count = 0;
    int unsigned flush_seen = 0;
    int unsigned ends_seen = 0;
    int unsigned phases_run = 0;
    int unsigned idle_cycles = 0;

    function automatic int unsigned hdr_effective();
        return (hdr_setting < HDR_MIN) ? int'(HDR_MIN) : int'(hdr_setting);
    endfunction

    function automatic int unsigned pick_gap(bit enabled);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Advance the packet state by one beat and return the result it gives.
    task automatic deframe_beat(input logic act, input logic [7:0] b, output t_out_beat r);
        int unsigned pos;
        int unsigned hdr;
        int unsigned len;
        bit          last;
        pos = frame_pos;
        hdr = hdr_effective();
        r = '{KIND_DATA, 8'h00, 16'h0000, 1'b0, 16'h0000};
        if (act == ACT_FLUSH) begin
            r.kind = KIND_FLUSH;
            r.partial_count = frame_pos;
            frame_pos = '0;
            len_word = '0;
            frame_len = '0;
            return;
        end
        if (pos < 4) begin
            if (be_setting)
                len_word = {len_word[23:0], b};
            else
                len_word = len_word | (32'(b) << (8 * pos));
        end
        // length is known once the header is in; never shorter than what came
        if (frame_len == 0 && pos + 1 >= hdr) begin
            len = len_word[15:0];
            if (len < hdr)
                len = hdr;
            if (len < pos + 1)
                len = pos + 1;
            frame_len = 16'(len);
        end
        last = (frame_len != 0) && (pos + 1 >= frame_len);
        r.out_byte = b;
        r.byte_offset = 16'(pos);
        r.packet_end = last;
        if (last) begin
            frame_pos = '0;
            len_word = '0;
            frame_len = '0;
        end else begin
            frame_pos = 16'(pos + 1);
        end
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic queue_beat(input logic act, input logic [7:0] b);
        pending_beats.push_back('{act, b});
        beats_queued++;
    endtask

    task automatic queue_flush();
        queue_beat(ACT_FLUSH, 8'($urandom));
    endtask

    // One packet with its length word in the current byte order; long or
    // chosen ones are cut short and flushed, an open one stops after one to six bytes, often mid-header.
    task automatic queue_packet(input bit keep_open);
        int unsigned hdr;
        int unsigned len;
        int unsigned full;
        int unsigned cut;
        int unsigned r;
        logic [31:0] word;
        logic [7:0]  b;
        hdr = hdr_effective();
        r = $urandom_range(0, 99);
        if (r < 60)
            len = $urandom_range(hdr, hdr + 24);
        else if (r < 75)
            len = $urandom_range(0, hdr - 1);
        else
            len = $urandom_range(0, 65535);
        word = {16'($urandom), 16'(len)};
        full = (len < hdr) ? hdr : len;
        cut = full;
        if (keep_open)
            cut = $urandom_range(1, 6);
        else if (full > hdr + 300 || $urandom_range(0, 9) == 0)
            cut = $urandom_range(0, (full < 40) ? full : 40);
        for (int unsigned i = 0; i < cut; i++) begin
            if (i < 4)
                b = be_setting ? word[8 * (3 - i) +: 8] : word[8 * i +: 8];
            else
                b = 8'($urandom);
            queue_beat(ACT_DATA, b);
        end
        if (!keep_open && cut < full)
            queue_flush();
    endtask

    // Hold until the block has nothing in flight, then let the pipe settle.
    task automatic wait_idle();
        while (pending_beats.size() != 0 || in_busy || expected_beats.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        if (idx == REG_HEADER_BYTES)
            hdr_setting = value;
        else if (idx == REG_LENGTH_BE)
            be_setting = value[0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic pick_settings();
        int unsigned r;
        logic [HDR_BITS-1:0] hdr;
        r = $urandom_range(0, 99);
        if (phases_run == 0)
            hdr = 8'd255;
        else if (phases_run == 1)
            hdr = 8'd0;
        else if (r < 30)
            hdr = HDR_MIN;
        else if (r < 50)
            hdr = 8'($urandom_range(0, 3));
        else if (r < 85)
            hdr = 8'($urandom_range(5, 16));
        else if (r < 95)
            hdr = 8'($urandom_range(17, 64));
        else
            hdr = 8'($urandom_range(200, 255));
        if (phases_run < 2 || $urandom_range(0, 3) != 0)
            write_reg(REG_HEADER_BYTES, hdr);
        if ($urandom_range(0, 2) != 0)
            write_reg(REG_LENGTH_BE, 8'($urandom));
        if ($urandom_range(0, 6) == 0)
            write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B, 8'($urandom));
    endtask

    initial begin : stimulus
        int unsigned n_packets;
        int unsigned n_noise;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: empty flush, header-only packet, packet whose length
        // word has its upper half set, then a partial packet ended by flush
        queue_flush();
        repeat (4) queue_beat(ACT_DATA, 8'h00);
        queue_beat(ACT_DATA, 8'h06);
        queue_beat(ACT_DATA, 8'h00);
        queue_beat(ACT_DATA, 8'hFF);
        queue_beat(ACT_DATA, 8'hFF);
        queue_beat(ACT_DATA, 8'h12);
        queue_beat(ACT_DATA, 8'h34);
        queue_beat(ACT_DATA, 8'hAB);
        queue_beat(ACT_DATA, 8'hCD);
        queue_flush();
        wait_idle();

        // header setting below four, big endian length word
        write_reg(REG_HEADER_BYTES, 8'd2);
        write_reg(REG_LENGTH_BE, 8'hFF);
        queue_beat(ACT_DATA, 8'h00);
        queue_beat(ACT_DATA, 8'h00);
        queue_beat(ACT_DATA, 8'h00);
        queue_beat(ACT_DATA, 8'h05);
        queue_beat(ACT_DATA, 8'h7F);
        wait_idle();

        // shrink the header mid-header below the bytes already in: end at once
        write_reg(REG_HEADER_BYTES, 8'd8);
        queue_beat(ACT_DATA, 8'h00);
        queue_beat(ACT_DATA, 8'h00);
        queue_beat(ACT_DATA, 8'h00);
        queue_beat(ACT_DATA, 8'h04);
        queue_beat(ACT_DATA, 8'hAA);
        queue_beat(ACT_DATA, 8'h55);
        wait_idle();
        write_reg(REG_HEADER_BYTES, HDR_MIN);
        queue_beat(ACT_DATA, 8'h80);

        while (beats_queued < 26 + RANDOM_BEATS) begin
            wait_idle();
            pick_settings();
            phases_run++;
            in_idle_on = ($urandom_range(0, 3) != 0);
            out_idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1) != 0)
                queue_flush();
            n_packets = (hdr_effective() > 64) ? $urandom_range(1, 2) : $urandom_range(3, 12);
            for (int unsigned p = 0; p < n_packets; p++) begin
                if ($urandom_range(0, 99) < 6) begin
                    n_noise = $urandom_range(1, 6);
                    repeat (n_noise) queue_beat(ACT_DATA, 8'($urandom));
                    queue_flush();
                end
                queue_packet(1'b0);
            end
            // leave some phases mid-header so the next settings land there
            if ($urandom_range(0, 4) == 0)
                queue_packet(1'b1);
        end

        wait_idle();
        repeat (8) @(negedge i_clk);
        $display("covered %0d beats in %0d random phases: %0d flush markers, %0d packet ends",
                 beats_queued, phases_run, flush_seen, ends_seen);
        $display("header sizes 0 through 255, both byte orders, mid-header setting changes");
        if (fail_count == 0)
            $display("length_prefixed_deframer: match");
        else
            $display("length_prefixed_deframer: mismatch");
        $finish;
    end

    always @(negedge i_clk) begin : beat_driver
        t_in_beat nb;
        if (i_rst_n) begin
            if (in_taken) begin
                in_taken = 1'b0;
                in_busy = 1'b0;
                in_gap = pick_gap(in_idle_on);
            end
            if (!in_busy) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_valid <= 1'b0;
                end else if (pending_beats.size() != 0) begin
                    nb = pending_beats.pop_front();
                    i_action <= nb.action;
                    i_data_byte <= nb.data;
                    i_valid <= 1'b1;
                    in_busy = 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(negedge i_clk) begin : stall_driver
        if (i_rst_n) begin
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                stall_left = pick_gap(out_idle_on);
            end
        end
    end

    always @(posedge i_clk) begin : beat_accept
        t_out_beat r;
        if (i_rst_n && i_valid && !o_stall) begin
            deframe_beat(i_action, i_data_byte, r);
            expected_beats.push_back(r);
            in_taken = 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_out_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_beats.size() == 0) begin
                $error("result beat with nothing expected");
                fail_count++;
            end else begin
                want = expected_beats.pop_front();
                check_field("kind", want.kind, o_kind);
                check_field("out_byte", want.out_byte, o_out_byte);
                check_field("byte_offset", want.byte_offset, o_byte_offset);
                check_field("packet_end", want.packet_end, o_packet_end);
                check_field("partial_count", want.partial_count, o_partial_count);
                if (want.kind == KIND_FLUSH)
                    flush_seen++;
                if (want.packet_end)
                    ends_seen++;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("timeout: %0d beats still expected", expected_beats.size());
            $display("length_prefixed_deframer: mismatch");
            $finish;
        end
    end

endmodule
